[hdl/osa_pkg.sv]
// shared types, codes and constant tables of the online softmax attention row block
package osa_pkg;

   typedef enum logic [1:0] {
      CMD_KEY   = 2'd0,
      CMD_VALUE = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_START = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_DIM    = 2'd0,
      REG_KEYS   = 2'd1,
      REG_CAUSAL = 2'd2,
      REG_SCALE  = 2'd3
   } reg_type;

   localparam int DOT_W   = 38;
   localparam int ACC_W   = 40;
   localparam int SCORE_W = 32;
   localparam int EXP_W   = 17;
   localparam int TOTAL_W = 32;

   localparam logic [6:0]  DIM_RESET   = 7'd64;
   localparam logic [10:0] KEYS_RESET  = 11'd1024;
   localparam logic [15:0] SCALE_RESET = 16'd8192;
   localparam logic signed [SCORE_W-1:0] PEAK_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic [16:0] EXP_ONE = 17'd65536;
   localparam logic [33:0] EXP_LIMIT = 34'd49152;

   typedef struct packed {
      logic [6:0]  dim;
      logic [10:0] keys;
      logic        causal;
      logic [15:0] scale;
   } cfg_type;

   typedef struct packed {
      logic        key_we;
      logic        value_we;
      logic        query_we;
      logic [9:0]  row;
      logic [5:0]  column;
      logic [15:0] value;
   } load_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLR, S_TILE, S_DRD, S_DMUL, S_DACC, S_SLO, S_SHI, S_SFIN,
      S_PEAK, S_CEXP, S_TLO, S_THI, S_TFIN, S_RRD, S_RLO, S_RHI, S_RWR,
      S_BEGC, S_WEXP, S_ARD, S_AMUL, S_AWR, S_ORD, S_OSTART, S_ODIV, S_OEMIT
   } core_state_type;

   typedef enum logic [2:0] {
      E_IDLE, E_MUL1, E_MUL2, E_CORR, E_FIN, E_OUT
   } exp_state_type;

   // exp(-n) in Q1.16, rounded
   function automatic logic [20:0] expn(input logic [3:0] n);
      logic [20:0] r;
      case (n)
         4'd0:    r = 21'd65536;
         4'd1:    r = 21'd24109;
         4'd2:    r = 21'd8869;
         4'd3:    r = 21'd3263;
         4'd4:    r = 21'd1200;
         4'd5:    r = 21'd442;
         4'd6:    r = 21'd162;
         4'd7:    r = 21'd60;
         4'd8:    r = 21'd22;
         4'd9:    r = 21'd8;
         4'd10:   r = 21'd3;
         4'd11:   r = 21'd1;
         default: r = 21'd0;
      endcase
      return r;
   endfunction

   // floor(2^20 / k) for the taylor step divisors
   function automatic logic [20:0] recip(input logic [2:0] k);
      logic [20:0] r;
      case (k)
         3'd1:    r = 21'd1048576;
         3'd2:    r = 21'd524288;
         3'd3:    r = 21'd349525;
         3'd4:    r = 21'd262144;
         3'd5:    r = 21'd209715;
         3'd6:    r = 21'd174762;
         default: r = 21'd0;
      endcase
      return r;
   endfunction

endpackage

[hdl/online_softmax_attention_row_top.sv]
// Online softmax attention for one query row. Key, value and query elements are loaded
// with one word per cycle while the core is idle (write commands are ignored when the row or
// column lies outside the stores). A start word walks the keys in tiles twice: a first
// pass finds the tile peak score, then sum and accumulators are rescaled and the
// exp-weighted value rows are added. Dot products, score scaling and rescaling share one
// 24x18 multiplier and the exp unit has a small multiplier of its own. A start clears the
// accumulators, waits on the exp unit for each attended key, rescales for each tile after
// the first and then runs the serial divider for each output word. The input is not ready
// from a start until its last result word is taken.
// The register of a start with a zero dimension produces no words.
module online_softmax_attention_row_top import osa_pkg::*; #(
   parameter int MAX_DIM  = 64,
   parameter int MAX_KEYS = 1024,
   parameter int TILE     = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // row[9:0], column[15:10], value[31:16], query_position[43:32]
   input  logic [1:0]  req_tuser,  // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_index[5:0], out_value[21:6]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [6:0]  dim_ff;
   logic [10:0] keys_ff;
   logic        causal_ff;
   logic [15:0] scale_ff;
   logic        csr_wr;
   logic        accept;
   cmd_type     cmd;
   logic        col_ok, row_ok;
   cfg_type     cfg;
   load_type    load;
   logic        core_idle;
   logic [5:0]  out_index;
   logic signed [15:0] out_value;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= DIM_RESET;
         keys_ff   <= KEYS_RESET;
         causal_ff <= 1'b0;
         scale_ff  <= SCALE_RESET;
      end else if (csr_wr) begin
         case (reg_type'(csr_paddr[3:2]))
            REG_DIM:    dim_ff    <= csr_pwdata[6:0];
            REG_KEYS:   keys_ff   <= csr_pwdata[10:0];
            REG_CAUSAL: causal_ff <= csr_pwdata[0];
            REG_SCALE:  scale_ff  <= csr_pwdata[15:0];
            default:    dim_ff    <= dim_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_type'(csr_paddr[3:2]))
         REG_DIM:    csr_prdata = {25'b0, dim_ff};
         REG_KEYS:   csr_prdata = {21'b0, keys_ff};
         REG_CAUSAL: csr_prdata = {31'b0, causal_ff};
         REG_SCALE:  csr_prdata = {16'b0, scale_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign req_tready = core_idle;
   assign accept = req_tvalid && req_tready;
   assign cmd    = cmd_type'(req_tuser);
   assign col_ok = {1'b0, req_tdata[15:10]} < 7'(MAX_DIM);
   assign row_ok = 17'(req_tdata[9:0]) < 17'(MAX_KEYS);

   assign cfg = '{dim: dim_ff, keys: keys_ff, causal: causal_ff, scale: scale_ff};

   always_comb begin
      load.key_we   = accept && col_ok && row_ok && (cmd == CMD_KEY);
      load.value_we = accept && col_ok && row_ok && (cmd == CMD_VALUE);
      load.query_we = accept && col_ok && (cmd == CMD_QUERY);
      load.row      = req_tdata[9:0];
      load.column   = req_tdata[15:10];
      load.value    = req_tdata[31:16];
   end

   osa_core #(.MAX_DIM(MAX_DIM), .MAX_KEYS(MAX_KEYS), .TILE(TILE)) u_core (
      .clock(clock),
      .reset(reset),
      .start(accept && (cmd == CMD_START)),
      .cfg(cfg),
      .qpos(req_tdata[43:32]),
      .load(load),
      .idle(core_idle),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_index(out_index),
      .rsp_value(out_value),
      .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b0, out_value, out_index};
endmodule

[hdl/osa_ram.sv]
// generic simple dual-port ram with registered read
module osa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/osa_exp.sv]
// iterative exp(-x/4096) unit, six taylor steps on one small multiplier
module osa_exp import osa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [33:0]  x,
   output logic                done,
   output logic [EXP_W-1:0]    res
);
   exp_state_type state_ff, state_in;
   logic [2:0]  k_ff, k_in;
   logic [15:0] f_ff, f_in;
   logic [16:0] t_ff, t_in;
   logic [16:0] x1_ff, x1_in;
   logic [3:0]  n_ff, n_in;
   logic [37:0] prod_ff;
   logic [16:0] res_ff, res_in;
   logic        done_ff, done_in;
   logic [16:0] ma;
   logic [20:0] mb;
   logic [33:0] xc;
   logic [16:0] q0;
   logic [19:0] rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      k_ff    <= k_in;
      f_ff    <= f_in;
      t_ff    <= t_in;
      x1_ff   <= x1_in;
      n_ff    <= n_in;
      res_ff  <= res_in;
      prod_ff <= 38'(ma) * 38'(mb);
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      f_in     = f_ff;
      t_in     = t_ff;
      x1_in    = x1_ff;
      n_in     = n_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      ma       = '0;
      mb       = '0;
      xc       = x[33] ? 34'd0 : x;
      q0       = prod_ff[36:20];
      rem      = 20'(x1_ff) - 20'(q0) * 20'(k_ff);
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               if (xc >= EXP_LIMIT) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else begin
                  n_in     = xc[15:12];
                  f_in     = {xc[11:0], 4'b0};
                  t_in     = EXP_ONE;
                  k_in     = 3'd6;
                  state_in = E_MUL1;
               end
            end
         end
         E_MUL1: begin
            ma       = t_ff;
            mb       = {5'b0, f_ff};
            state_in = E_MUL2;
         end
         E_MUL2: begin
            // scale by 1/65536, divide by k as a reciprocal product, then one correction
            x1_in    = prod_ff[32:16];
            ma       = prod_ff[32:16];
            mb       = recip(k_ff);
            state_in = E_CORR;
         end
         E_CORR: begin
            t_in = EXP_ONE - ((rem >= 20'(k_ff)) ? q0 + 17'd1 : q0);
            if (k_ff == 3'd1) begin
               state_in = E_FIN;
            end else begin
               k_in     = k_ff - 3'd1;
               state_in = E_MUL1;
            end
         end
         E_FIN: begin
            ma       = t_ff;
            mb       = expn(n_ff);
            state_in = E_OUT;
         end
         E_OUT: begin
            res_in   = prod_ff[32:16];
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: state_in = E_IDLE;
      endcase
   end

   assign done = done_ff;
   assign res  = res_ff;
endmodule

[hdl/osa_div.sv]
// serial restoring divider, one quotient bit per cycle, saturated q4.12 result
module osa_div import osa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] dividend,
   input  logic [31:0]        divisor,
   output logic               done,
   output logic signed [15:0] res
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] div_ff, div_in;
   logic        neg_ff, neg_in;
   logic signed [15:0] res_ff, res_in;
   logic [32:0] rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      rem_sh  = {rem_ff[31:0], quo_ff[47]};
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[47] ? 48'(-dividend) : dividend;
         neg_in  = dividend[47];
         div_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sh - {1'b0, div_ff};
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               res_in = (quo_in > 48'd32768) ? 16'sh8000 : 16'(-quo_in);
            end else begin
               res_in = (quo_in > 48'd32767) ? 16'sh7fff : 16'(quo_in);
            end
         end
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
endmodule

[hdl/osa_core.sv]
// sequencer: stores, shared multiplier, tile walk with running peak and rescale
module osa_core import osa_pkg::*; #(
   parameter int MAX_DIM  = 64,
   parameter int MAX_KEYS = 1024,
   parameter int TILE     = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  cfg_type            cfg,
   input  logic [11:0]        qpos,
   input  load_type           load,
   output logic               idle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_index,
   output logic signed [15:0] rsp_value,
   output logic               rsp_last
);
   localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int KIDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W  = $clog2(MAX_KEYS + 4096 + TILE + 1);
   localparam int KV_DEPTH = MAX_KEYS * (2 ** DIM_W);

   core_state_type state_ff, state_in;
   logic [6:0]       dim_ff, dim_in;
   logic [CNT_W-1:0] n_end_ff, n_end_in, lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in;
   logic [DIM_W-1:0] d_ff, d_in;
   logic             pass_ff, pass_in;
   logic signed [DOT_W-1:0]   dot_ff, dot_in;
   logic signed [55:0]        sacc_ff, sacc_in;
   logic signed [SCORE_W-1:0] local_ff, local_in, peak_ff, peak_in;
   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic [EXP_W-1:0]          c_ff, c_in;
   logic signed [15:0]        res_ff, res_in;
   logic signed [41:0]        prod_ff;
   logic signed [23:0]        mul_a;
   logic signed [17:0]        mul_b;

   logic [15:0] q_rd, k_rd, v_rd;
   logic [ACC_W-1:0] acc_rd, acc_wd;
   logic acc_we;

   logic             exp_start, exp_done;
   logic signed [33:0] exp_x;
   logic [EXP_W-1:0] exp_res;
   logic             div_start, div_done;
   logic signed [15:0] div_res;

   logic              last_d;
   logic [6:0]        dim_new;
   logic [CNT_W-1:0]  nkv, att;
   logic signed [55:0] sfull;
   logic signed [SCORE_W-1:0] score, peak_new;
   logic [49:0]       tsum;
   logic signed [59:0] rfull;
   logic signed [41:0] pw;
   logic signed [42:0] asum;
   logic [32:0]       tadd;

   osa_ram #(.WIDTH(16), .DEPTH(KV_DEPTH)) u_key_ram (
      .clock(clock), .wr_en(load.key_we),
      .wr_addr({KIDX_W'(load.row), DIM_W'(load.column)}), .wr_data(load.value),
      .rd_addr({j_ff[KIDX_W-1:0], d_ff}), .rd_data(k_rd));

   osa_ram #(.WIDTH(16), .DEPTH(KV_DEPTH)) u_value_ram (
      .clock(clock), .wr_en(load.value_we),
      .wr_addr({KIDX_W'(load.row), DIM_W'(load.column)}), .wr_data(load.value),
      .rd_addr({j_ff[KIDX_W-1:0], d_ff}), .rd_data(v_rd));

   osa_ram #(.WIDTH(16), .DEPTH(2 ** DIM_W)) u_query_ram (
      .clock(clock), .wr_en(load.query_we), .wr_addr(DIM_W'(load.column)),
      .wr_data(load.value), .rd_addr(d_ff), .rd_data(q_rd));

   osa_ram #(.WIDTH(ACC_W), .DEPTH(2 ** DIM_W)) u_acc_ram (
      .clock(clock), .wr_en(acc_we), .wr_addr(d_ff), .wr_data(acc_wd),
      .rd_addr(d_ff), .rd_data(acc_rd));

   osa_exp u_exp (
      .clock(clock), .reset(reset), .start(exp_start), .x(exp_x),
      .done(exp_done), .res(exp_res));

   osa_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend({acc_rd, 8'b0}),
      .divisor(total_ff), .done(div_done), .res(div_res));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dim_ff   <= dim_in;
      n_end_ff <= n_end_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      j_ff     <= j_in;
      d_ff     <= d_in;
      pass_ff  <= pass_in;
      dot_ff   <= dot_in;
      sacc_ff  <= sacc_in;
      local_ff <= local_in;
      peak_ff  <= peak_in;
      total_ff <= total_in;
      c_ff     <= c_in;
      res_ff   <= res_in;
      prod_ff  <= mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      dim_in   = dim_ff;
      n_end_in = n_end_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      j_in     = j_ff;
      d_in     = d_ff;
      pass_in  = pass_ff;
      dot_in   = dot_ff;
      sacc_in  = sacc_ff;
      local_in = local_ff;
      peak_in  = peak_ff;
      total_in = total_ff;
      c_in     = c_ff;
      res_in   = res_ff;
      mul_a    = '0;
      mul_b    = '0;
      acc_we   = 1'b0;
      acc_wd   = '0;
      exp_start = 1'b0;
      exp_x    = '0;
      div_start = 1'b0;

      last_d   = (7'(d_ff) == dim_ff - 7'd1);
      dim_new  = (cfg.dim > 7'(MAX_DIM)) ? 7'(MAX_DIM) : cfg.dim;
      nkv      = (CNT_W'(cfg.keys) > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(cfg.keys);
      att      = cfg.causal ? CNT_W'(qpos) + CNT_W'(1) : nkv;
      // dot * scale never leaves 28 bits after the shift, so no clamp is needed
      sfull    = sacc_ff + ({{14{prod_ff[41]}}, prod_ff} <<< 19);
      score    = {{4{sfull[55]}}, sfull[55:28]};
      peak_new = (local_ff > peak_ff) ? local_ff : peak_ff;
      tsum     = ({prod_ff[33:0], 16'b0}) + 50'(sacc_ff[33:0]);
      rfull    = ({{18{prod_ff[41]}}, prod_ff} <<< 20) + {{4{sacc_ff[55]}}, sacc_ff};
      pw       = prod_ff >>> 8;
      asum     = {{3{acc_rd[ACC_W-1]}}, acc_rd} + {pw[41], pw};
      tadd     = {1'b0, total_ff} + 33'(exp_res);

      case (state_ff)
         S_IDLE: begin
            if (start && dim_new != 7'd0) begin
               dim_in   = dim_new;
               n_end_in = (att < nkv) ? att : nkv;
               total_in = '0;
               peak_in  = PEAK_MIN;
               lo_in    = '0;
               d_in     = '0;
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            acc_we = 1'b1;
            if (last_d) begin
               d_in     = '0;
               state_in = S_TILE;
            end else begin
               d_in = d_ff + DIM_W'(1);
            end
         end
         S_TILE: begin
            d_in = '0;
            if (lo_ff >= n_end_ff) begin
               state_in = S_ORD;
            end else begin
               hi_in    = (lo_ff + CNT_W'(TILE) >= n_end_ff) ? n_end_ff
                                                              : lo_ff + CNT_W'(TILE);
               j_in     = lo_ff;
               local_in = PEAK_MIN;
               pass_in  = 1'b0;
               state_in = S_DRD;
            end
         end
         S_DRD: begin
            if (d_ff == '0) begin
               dot_in = '0;
            end
            state_in = S_DMUL;
         end
         S_DMUL: begin
            mul_a    = {{8{q_rd[15]}}, q_rd};
            mul_b    = {{2{k_rd[15]}}, k_rd};
            state_in = S_DACC;
         end
         S_DACC: begin
            dot_in = dot_ff + prod_ff[DOT_W-1:0];
            if (last_d) begin
               d_in     = '0;
               state_in = S_SLO;
            end else begin
               d_in     = d_ff + DIM_W'(1);
               state_in = S_DRD;
            end
         end
         S_SLO: begin
            mul_a    = {5'b0, dot_ff[18:0]};
            mul_b    = {2'b0, cfg.scale};
            state_in = S_SHI;
         end
         S_SHI: begin
            sacc_in  = {{14{prod_ff[41]}}, prod_ff};
            mul_a    = {{5{dot_ff[DOT_W-1]}}, dot_ff[DOT_W-1:19]};
            mul_b    = {2'b0, cfg.scale};
            state_in = S_SFIN;
         end
         S_SFIN: begin
            if (!pass_ff) begin
               if (score > local_ff) begin
                  local_in = score;
               end
               if (j_ff + CNT_W'(1) == hi_ff) begin
                  state_in = S_PEAK;
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = S_DRD;
               end
            end else begin
               exp_start = 1'b1;
               exp_x     = {{2{peak_ff[31]}}, peak_ff} - {{2{score[31]}}, score};
               state_in  = S_WEXP;
            end
         end
         S_PEAK: begin
            peak_in = peak_new;
            if (total_ff != '0) begin
               exp_start = 1'b1;
               exp_x     = {{2{peak_new[31]}}, peak_new} - {{2{peak_ff[31]}}, peak_ff};
               state_in  = S_CEXP;
            end else begin
               state_in = S_BEGC;
            end
         end
         S_CEXP: begin
            if (exp_done) begin
               c_in     = exp_res;
               state_in = S_TLO;
            end
         end
         S_TLO: begin
            mul_a    = {8'b0, total_ff[15:0]};
            mul_b    = {1'b0, c_ff};
            state_in = S_THI;
         end
         S_THI: begin
            sacc_in  = {{14{prod_ff[41]}}, prod_ff};
            mul_a    = {8'b0, total_ff[31:16]};
            mul_b    = {1'b0, c_ff};
            state_in = S_TFIN;
         end
         S_TFIN: begin
            total_in = tsum[47:16];
            d_in     = '0;
            state_in = S_RRD;
         end
         S_RRD: state_in = S_RLO;
         S_RLO: begin
            mul_a    = {4'b0, acc_rd[19:0]};
            mul_b    = {1'b0, c_ff};
            state_in = S_RHI;
         end
         S_RHI: begin
            sacc_in  = {{14{prod_ff[41]}}, prod_ff};
            mul_a    = {{4{acc_rd[ACC_W-1]}}, acc_rd[ACC_W-1:20]};
            mul_b    = {1'b0, c_ff};
            state_in = S_RWR;
         end
         S_RWR: begin
            acc_we = 1'b1;
            acc_wd = rfull[55:16];
            if (last_d) begin
               state_in = S_BEGC;
            end else begin
               d_in     = d_ff + DIM_W'(1);
               state_in = S_RRD;
            end
         end
         S_BEGC: begin
            pass_in  = 1'b1;
            j_in     = lo_ff;
            d_in     = '0;
            state_in = S_DRD;
         end
         S_WEXP: begin
            if (exp_done) begin
               c_in     = exp_res;
               total_in = tadd[32] ? '1 : tadd[31:0];
               d_in     = '0;
               state_in = S_ARD;
            end
         end
         S_ARD: state_in = S_AMUL;
         S_AMUL: begin
            mul_a    = {7'b0, c_ff};
            mul_b    = {{2{v_rd[15]}}, v_rd};
            state_in = S_AWR;
         end
         S_AWR: begin
            acc_we = 1'b1;
            if (!asum[42] && asum[41:39] != 3'b000) begin
               acc_wd = {1'b0, {(ACC_W-1){1'b1}}};
            end else if (asum[42] && asum[41:39] != 3'b111) begin
               acc_wd = {1'b1, {(ACC_W-1){1'b0}}};
            end else begin
               acc_wd = asum[ACC_W-1:0];
            end
            if (last_d) begin
               d_in = '0;
               if (j_ff + CNT_W'(1) == hi_ff) begin
                  lo_in    = hi_ff;
                  state_in = S_TILE;
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = S_DRD;
               end
            end else begin
               d_in     = d_ff + DIM_W'(1);
               state_in = S_ARD;
            end
         end
         S_ORD: state_in = S_OSTART;
         S_OSTART: begin
            if (total_ff == '0) begin
               res_in   = '0;
               state_in = S_OEMIT;
            end else begin
               div_start = 1'b1;
               state_in  = S_ODIV;
            end
         end
         S_ODIV: begin
            if (div_done) begin
               res_in   = div_res;
               state_in = S_OEMIT;
            end
         end
         S_OEMIT: begin
            if (rsp_ready) begin
               if (last_d) begin
                  state_in = S_IDLE;
               end else begin
                  d_in     = d_ff + DIM_W'(1);
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign idle      = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OEMIT);
   assign rsp_index = 6'(d_ff);
   assign rsp_value = res_ff;
   assign rsp_last  = last_d;
endmodule
